/* rtl/spq_pkg.sv */
// Shared types, codes and widths for the sorted priority queue.
package spq_pkg;

    // Fixed widths of the interface fields.
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 5;

    // Default sizing of the cell chain.
    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes on the kind field.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

    // Status codes on the result.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Action broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

endpackage

/* rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds a key and payload, shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                    clk,
    input  cell_op_t                op,
    input  logic [KEY_BITS-1:0]     new_key,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic                    occupied,
    input  logic                    left_take,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    output logic                    take,
    output logic [KEY_BITS-1:0]     key,
    output logic [PAYLOAD_BITS-1:0] payload
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    // The new entry goes at or before this cell unless this cell holds a key
    // that is not greater; equal keys stay ahead so ties leave in arrival order.
    assign take = !(occupied && (key_reg <= new_key));

    // Next contents: the first taking cell loads the new entry, later ones
    // take their left neighbor's; a pop moves everything one place left.
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        case (op)
            CELL_INSERT:
            begin
                if (take && !left_take)
                begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end
                else if (take)
                begin
                    key_next     = left_key;
                    payload_next = left_payload;
                end
            end
            CELL_POP:
            begin
                key_next     = right_key;
                payload_next = right_payload;
            end
            default:
            begin
                key_next     = key_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    // Entry storage needs no reset; only slots below the fill count are read.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

/* rtl/sorted_priority_queue_with_capacity_top.sv */
// Top level of the sorted priority queue: command decode, fill count and the cell chain.
//
// A transaction accepted on start is answered by done in the following cycle
// with status, head_key and head_payload, and busy stays low, so a command
// may be issued in every cycle. The chain of DEPTH cells makes this possible:
// all cells compare their stored key with the new key in parallel and shift
// in the same edge. The receiver cannot stall: each result is shown for
// exactly one cycle. Entries are kept in ascending key order, equal keys in
// arrival order; an insert is refused with status full once the fill count
// reaches the smaller of the capacity register and DEPTH. The capacity
// register is written over the cfg channel, which is always ready; the user
// must write it only while the queue is idle, which the block does not enforce.
module sorted_priority_queue_with_capacity_top
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    kind,
    input  logic [KEY_W-1:0]     key,
    input  logic [PAYLOAD_W-1:0] payload,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [KEY_W-1:0]     head_key,
    output logic [PAYLOAD_W-1:0] head_payload,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [KEY_W-1:0]     head_key_reg;
    logic [KEY_W-1:0]     head_key_next;
    logic [PAYLOAD_W-1:0] head_payload_reg;
    logic [PAYLOAD_W-1:0] head_payload_next;

    logic [KEY_BITS-1:0]     in_key;
    logic [PAYLOAD_BITS-1:0] in_payload;
    logic [KEY_W-1:0]        top_key;
    logic [PAYLOAD_W-1:0]    top_payload;
    logic [CMP_W-1:0]        limit;
    logic                    full;
    logic                    empty;
    logic                    accept;
    cell_op_t                op;

    logic [KEY_BITS-1:0]     chain_key     [DEPTH+1];
    logic [PAYLOAD_BITS-1:0] chain_payload [DEPTH+1];
    logic                    chain_take    [DEPTH+1];

    // Every command is answered without stalling, so the queue never holds start off.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Fit the fixed-width fields to the stored widths and back.
    generate
        if (KEY_BITS >= KEY_W)
        begin : g_key_wide
            assign in_key  = KEY_BITS'(key);
            assign top_key = chain_key[1][KEY_W-1:0];
        end
        else
        begin : g_key_narrow
            assign in_key  = key[KEY_BITS-1:0];
            assign top_key = KEY_W'(chain_key[1]);
        end
        if (PAYLOAD_BITS >= PAYLOAD_W)
        begin : g_pay_wide
            assign in_payload  = PAYLOAD_BITS'(payload);
            assign top_payload = chain_payload[1][PAYLOAD_W-1:0];
        end
        else
        begin : g_pay_narrow
            assign in_payload  = payload[PAYLOAD_BITS-1:0];
            assign top_payload = PAYLOAD_W'(chain_payload[1]);
        end
    endgenerate

    // Effective capacity is the register clipped to the chain depth.
    assign limit = (CMP_W'(cap_reg) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_reg);
    assign full  = CMP_W'(count_reg) >= limit;
    assign empty = (count_reg == '0);

    // Command decode: chain action, new count and the result fields.
    always_comb
    begin
        op                = CELL_HOLD;
        count_next        = count_reg;
        status_next       = ST_OK;
        head_key_next     = '0;
        head_payload_next = '0;
        case (kind)
            KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op         = CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_key_next     = top_key;
                    head_payload_next = top_payload;
                end
            end
            KIND_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    op         = CELL_POP;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op = CELL_HOLD;
            end
        endcase
        if (!accept)
        begin
            op         = CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Ends of the chain: nothing takes before the head, empty data past the tail.
    assign chain_take[0]          = 1'b0;
    assign chain_key[0]           = '0;
    assign chain_payload[0]       = '0;

    logic [KEY_BITS-1:0]     tail_key;
    logic [PAYLOAD_BITS-1:0] tail_payload;
    assign tail_key     = '0;
    assign tail_payload = '0;

    // Row of cells; cell i sits at chain index i+1, the head at index one.
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [KEY_BITS-1:0]     r_key;
            logic [PAYLOAD_BITS-1:0] r_payload;
            if (i == DEPTH - 1)
            begin : g_last
                assign r_key     = tail_key;
                assign r_payload = tail_payload;
            end
            else
            begin : g_mid
                assign r_key     = chain_key[i+2];
                assign r_payload = chain_payload[i+2];
            end
            spq_cell #(
                .KEY_BITS     (KEY_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .op            (op),
                .new_key       (in_key),
                .new_payload   (in_payload),
                .occupied      (count_reg > CNT_W'(i)),
                .left_take     (chain_take[i]),
                .left_key      (chain_key[i]),
                .left_payload  (chain_payload[i]),
                .right_key     (r_key),
                .right_payload (r_payload),
                .take          (chain_take[i+1]),
                .key           (chain_key[i+1]),
                .payload       (chain_payload[i+1])
            );
        end
    endgenerate

    // Control state: capacity register, fill count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result fields, captured with each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg       <= status_next;
            head_key_reg     <= head_key_next;
            head_payload_reg <= head_payload_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign head_key     = head_key_reg;
    assign head_payload = head_payload_reg;

endmodule
